[design/bdlp_pkg.sv]
// bdlp_pkg: shared types and constants for the button debounce / long press block
// no dependencies

package bdlp_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned IntvW  = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgDebounceMs  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgLongPressMs = CfgIdxW'(1);

  localparam logic [IntvW-1:0] DebounceMsRst  = IntvW'(50);
  localparam logic [IntvW-1:0] LongPressMsRst = IntvW'(250);

  typedef struct packed {
    logic [IntvW-1:0] debounce_ms;
    logic [IntvW-1:0] long_press_ms;
  } cfg_t;

  typedef struct packed {
    logic pressed;
    logic changed;
    logic long_press;
  } result_t;

endpackage

[design/bdlp_if.sv]
// bdlp_if: valid/ready channel interfaces for polls, results and register writes
// depends on bdlp_pkg

interface bdlp_poll_if;
  logic                       valid;
  logic                       ready;
  logic                       raw_level;
  logic [bdlp_pkg::TimeW-1:0] now_ms;

  modport source (output valid, output raw_level, output now_ms, input ready);
  modport sink   (input valid, input raw_level, input now_ms, output ready);
endinterface

interface bdlp_result_if;
  logic valid;
  logic ready;
  logic pressed;
  logic changed;
  logic long_press;

  modport source (output valid, output pressed, output changed, output long_press,
                  input ready);
  modport sink   (input valid, input pressed, input changed, input long_press,
                  output ready);
endinterface

interface bdlp_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [bdlp_pkg::CfgIdxW-1:0] index;
  logic [bdlp_pkg::IntvW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[design/bdlp_core.sv]
// bdlp_core: debounce and long press state plus the per-poll update logic
// depends on bdlp_pkg

module bdlp_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       acc_i,
  input  logic                       raw_i,
  input  logic [bdlp_pkg::TimeW-1:0] now_i,
  input  bdlp_pkg::cfg_t             cfg_i,
  output bdlp_pkg::result_t          res_o
);

  logic                       prev_raw_q, prev_raw_d;
  logic [bdlp_pkg::TimeW-1:0] change_time_q, change_time_d;
  logic                       stable_q, stable_d;
  logic                       changed_q, changed_d;
  logic                       long_q, long_d;
  logic [bdlp_pkg::TimeW-1:0] press_time_q, press_time_d;

  logic [bdlp_pkg::TimeW-1:0] since_press;
  logic [bdlp_pkg::TimeW-1:0] since_change;
  logic                       edge_seen;
  logic                       take_level;

  always_comb begin
    edge_seen     = raw_i != prev_raw_q;
    change_time_d = edge_seen ? now_i : change_time_q;
    changed_d     = edge_seen ? changed_q : 1'b0;

    // long press check runs against the stable level before acceptance
    since_press = now_i - press_time_q;
    long_d      = long_q;
    if (stable_q && !long_q &&
        since_press >= bdlp_pkg::TimeW'(cfg_i.long_press_ms)) begin
      long_d = 1'b1;
    end

    since_change = now_i - change_time_d;
    take_level   = (since_change >= bdlp_pkg::TimeW'(cfg_i.debounce_ms)) &&
                   (raw_i != stable_q);
    stable_d     = stable_q;
    press_time_d = press_time_q;
    if (take_level) begin
      stable_d  = raw_i;
      changed_d = 1'b1;
      if (raw_i) begin
        press_time_d = now_i;
        long_d       = 1'b0;
      end
    end
    prev_raw_d = raw_i;

    res_o.pressed    = stable_d;
    res_o.changed    = changed_d;
    res_o.long_press = long_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_raw_q    <= 1'b0;
      change_time_q <= '0;
      stable_q      <= 1'b0;
      changed_q     <= 1'b0;
      long_q        <= 1'b0;
      press_time_q  <= '0;
    end else if (acc_i) begin
      prev_raw_q    <= prev_raw_d;
      change_time_q <= change_time_d;
      stable_q      <= stable_d;
      changed_q     <= changed_d;
      long_q        <= long_d;
      press_time_q  <= press_time_d;
    end
  end

  // steady poll: changed is set exactly when the stable level moved
  a_changed_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && (raw_i == prev_raw_q) |=> changed_q == ($past(stable_q) != stable_q))
    else $error("changed flag disagrees with stable level movement");

  a_stable_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc_i |=> $stable(stable_q) && $stable(long_q) && $stable(changed_q))
    else $error("state moved without an accepted poll");

  a_long_needs_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(long_q) |-> $past(stable_q))
    else $error("long press flagged while released");

  a_press_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(stable_q) |-> (press_time_q == $past(now_i)) && !long_q)
    else $error("press time not captured on press");

endmodule

[design/button_debounce_long_press_top.sv]
// button_debounce_long_press_top: top level of the push button debouncer
// depends on bdlp_pkg, bdlp_if and bdlp_core

// Each poll request carries the raw pin level and a 32-bit millisecond
// timestamp and yields exactly one result request (pressed, changed,
// long_press). A poll is processed in the cycle it is accepted and its
// result appears in the output register on the next cycle, so the block
// sustains one poll per clock; the only thing that holds poll_i.ready low
// is a result sitting in the output register that the sink has not taken
// in the same cycle. The debounce and long press intervals are written
// through cfg_i (index 0 debounce_ms, index 1 long_press_ms, other indexes
// ignored, reset values 50 and 250) and should only be changed while no
// poll is in flight. Time differences wrap modulo 2^32, so out-of-order
// timestamps are simply treated as very long intervals.

module button_debounce_long_press_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  bdlp_poll_if.sink     poll_i,
  bdlp_result_if.source result_o,
  bdlp_cfg_if.sink      cfg_i
);

  bdlp_pkg::cfg_t    cfg_q;
  bdlp_pkg::result_t res_d;
  bdlp_pkg::result_t res_q;
  logic              out_valid_q;
  logic              poll_acc;

  // config writes are always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms   <= bdlp_pkg::DebounceMsRst;
      cfg_q.long_press_ms <= bdlp_pkg::LongPressMsRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        bdlp_pkg::CfgDebounceMs:  cfg_q.debounce_ms   <= cfg_i.data;
        bdlp_pkg::CfgLongPressMs: cfg_q.long_press_ms <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // output register frees up in the same cycle it is drained
  assign poll_i.ready = !out_valid_q || result_o.ready;
  assign poll_acc     = poll_i.valid && poll_i.ready;

  bdlp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (poll_acc),
    .raw_i  (poll_i.raw_level),
    .now_i  (poll_i.now_ms),
    .cfg_i  (cfg_q),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (poll_acc) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk_i) begin
    if (poll_acc) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.pressed    = res_q.pressed;
  assign result_o.changed    = res_q.changed;
  assign result_o.long_press = res_q.long_press;

  // a stalled result must never be overwritten by a new poll
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !result_o.ready |-> !poll_acc)
    else $error("poll accepted over a pending result");

  // every accepted poll leaves a result pending on the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    poll_acc |=> out_valid_q)
    else $error("accepted poll produced no result");

  a_result_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !result_o.ready |=> $stable(res_q))
    else $error("pending result changed");

endmodule

[tb/bdlp_poll_checker.sv]
// bdlp_poll_checker: watches the poll, result and register write channels of the
// button debouncer, predicts each result and compares it with what the block returns
// depends on bdlp_pkg and bdlp_if

module bdlp_poll_checker
  import bdlp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  bdlp_poll_if        poll_i,
  bdlp_result_if      result_i,
  bdlp_cfg_if         cfg_i,
  output int unsigned fail_count_o,
  output int unsigned awaiting_o
);

  localparam int unsigned ShownMax = 10;

  // debouncer model state
  cfg_t             intervals;
  logic             last_raw;
  logic [TimeW-1:0] edge_ms;
  logic             stable_q;
  logic             changed_q;
  logic             long_q;
  logic [TimeW-1:0] press_ms;

  result_t expected_q[$];

  function automatic result_t predict_poll(input logic raw, input logic [TimeW-1:0] now);
    result_t          res;
    logic [TimeW-1:0] since_press;
    logic [TimeW-1:0] since_edge;
    if (raw != last_raw) begin
      edge_ms = now;
    end else begin
      changed_q = 1'b0;
    end
    since_press = now - press_ms;
    if (stable_q && !long_q && since_press >= TimeW'(intervals.long_press_ms)) begin
      long_q = 1'b1;
    end
    since_edge = now - edge_ms;
    if (since_edge >= TimeW'(intervals.debounce_ms) && raw != stable_q) begin
      if (raw) begin
        press_ms = now;
        long_q   = 1'b0;
      end
      stable_q  = raw;
      changed_q = 1'b1;
    end
    last_raw       = raw;
    res.pressed    = stable_q;
    res.changed    = changed_q;
    res.long_press = long_q;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t got;
    if (!rst_ni) begin
      intervals.debounce_ms   = DebounceMsRst;
      intervals.long_press_ms = LongPressMsRst;
      last_raw     = 1'b0;
      edge_ms      = '0;
      stable_q     = 1'b0;
      changed_q    = 1'b0;
      long_q       = 1'b0;
      press_ms     = '0;
      expected_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CfgDebounceMs:  intervals.debounce_ms   = cfg_i.data;
          CfgLongPressMs: intervals.long_press_ms = cfg_i.data;
          default: ;
        endcase
      end
      if (result_i.valid && result_i.ready) begin
        got.pressed    = result_i.pressed;
        got.changed    = result_i.changed;
        got.long_press = result_i.long_press;
        if (expected_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= ShownMax) begin
            $display("unexpected result request: pressed=%b changed=%b long=%b",
                     got.pressed, got.changed, got.long_press);
          end
        end else begin
          want = expected_q.pop_front();
          if (got.pressed !== want.pressed || got.changed !== want.changed ||
              got.long_press !== want.long_press) begin
            fail_count_o++;
            if (fail_count_o <= ShownMax) begin
              $display("result mismatch: expected pressed=%b changed=%b long=%b, got %b %b %b",
                       want.pressed, want.changed, want.long_press,
                       got.pressed, got.changed, got.long_press);
            end
          end
        end
      end
      if (poll_i.valid && poll_i.ready) begin
        expected_q.push_back(predict_poll(poll_i.raw_level, poll_i.now_ms));
      end
    end
    awaiting_o = expected_q.size();
  end

endmodule

[tb/button_debounce_long_press_top_tb.sv]
// button_debounce_long_press_top_tb: drives polls and register writes into the
// debouncer and gives the verdict; prediction and checking live in bdlp_poll_checker
// depends on bdlp_pkg, bdlp_if, bdlp_poll_checker and button_debounce_long_press_top

module button_debounce_long_press_top_tb;
  import bdlp_pkg::*;

  // register indexes the block must ignore
  localparam logic [CfgIdxW-1:0] CfgUnusedA = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgUnusedB = CfgIdxW'(3);

  localparam int unsigned NumPhases   = 8;
  localparam int unsigned PhaseItems  = 120;   // phases overrun a little, about 1050 polls in all
  localparam int unsigned RunLimit    = 8_000_000;

  logic clk_i;
  logic rst_ni;

  bdlp_poll_if   poll_ch ();
  bdlp_result_if result_ch ();
  bdlp_cfg_if    cfg_ch ();

  int unsigned fail_count;
  int unsigned awaiting;

  // stimulus bookkeeping
  logic [TimeW-1:0] now_ms_r;      // timestamp of the last poll sent
  int unsigned      db_cur;        // debounce interval currently in the block
  int unsigned      lp_cur;        // long press interval currently in the block
  int unsigned      issued;        // polls accepted so far
  logic             no_stall;      // stretch with no idling on either side

  button_debounce_long_press_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .poll_i   (poll_ch),
    .result_o (result_ch),
    .cfg_i    (cfg_ch)
  );

  bdlp_poll_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .poll_i       (poll_ch),
    .result_i     (result_ch),
    .cfg_i        (cfg_ch),
    .fail_count_o (fail_count),
    .awaiting_o   (awaiting)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side: ready toggles between random stretches, held high in no_stall mode
  initial begin
    int unsigned stall_left;
    int unsigned gap;
    stall_left      = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (no_stall) begin
        result_ch.ready = 1'b1;
        stall_left      = 0;
      end else if (stall_left != 0) begin
        stall_left--;
      end else if (result_ch.ready) begin
        gap = pick_gap();
        if (gap != 0) begin
          result_ch.ready = 1'b0;
          stall_left      = gap - 1;
        end else begin
          stall_left = $urandom_range(0, 15);
        end
      end else begin
        result_ch.ready = 1'b1;
        stall_left      = $urandom_range(0, 15);
      end
    end
  end

  // one poll request, with a random gap ahead of it; valid stays high on return
  // so that back-to-back polls never drop it
  task automatic send_poll(input logic raw, input logic [TimeW-1:0] stamp);
    int unsigned gap;
    gap = no_stall ? 0 : pick_gap();
    if (gap != 0) begin
      poll_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    poll_ch.valid     = 1'b1;
    poll_ch.raw_level = raw;
    poll_ch.now_ms    = stamp;
    do @(posedge clk_i); while (!poll_ch.ready);
    @(negedge clk_i);
    issued++;
  endtask

  task automatic poll_abs(input logic raw, input logic [TimeW-1:0] stamp);
    now_ms_r = stamp;
    send_poll(raw, now_ms_r);
  endtask

  // advance the timestamp by step ms and poll
  task automatic poll_at(input logic raw, input int unsigned step);
    now_ms_r = now_ms_r + TimeW'(step);
    send_poll(raw, now_ms_r);
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain_polls();
    poll_ch.valid = 1'b0;
    while (awaiting != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  // register write request, only issued once the block is idle
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [IntvW-1:0] val);
    drain_polls();
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
    if (idx == CfgDebounceMs) begin
      db_cur = 32'(val);
    end else if (idx == CfgLongPressMs) begin
      lp_cur = 32'(val);
    end
  endtask

  // contact chatter that settles on level; each step is at most a quarter of the debounce time plus one ms
  task automatic bounce_to(input logic level);
    int unsigned n;
    n = $urandom_range(0, 3);
    repeat (n) begin
      poll_at(level, $urandom_range(0, db_cur / 4 + 1));
      poll_at(!level, $urandom_range(0, db_cur / 4 + 1));
    end
    poll_at(level, $urandom_range(0, db_cur / 4 + 1));
  endtask

  // steady level for a few polls; sometimes long enough for a long press, sometimes not
  task automatic hold_level(input logic level);
    int unsigned m;
    m = $urandom_range(1, 6);
    repeat (m) poll_at(level, $urandom_range(0, (db_cur + lp_cur) / 3 + 2));
  endtask

  // a complete press and release with random timing
  task automatic press_episode();
    bounce_to(1'b1);
    hold_level(1'b1);
    bounce_to(1'b0);
    hold_level(1'b0);
  endtask

  initial begin
    int unsigned phase;
    int unsigned phase_end;
    int unsigned pick;
    logic [IntvW-1:0] db_tab [NumPhases];
    logic [IntvW-1:0] lp_tab [NumPhases];

    // every input known from time zero
    rst_ni            = 1'b0;
    poll_ch.valid     = 1'b0;
    poll_ch.raw_level = 1'b0;
    poll_ch.now_ms    = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = CfgDebounceMs;
    cfg_ch.data       = '0;
    now_ms_r          = '0;
    db_cur            = 32'(DebounceMsRst);
    lp_cur            = 32'(LongPressMsRst);
    issued            = 0;
    no_stall          = 1'b0;

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed part, reset intervals 50 / 250
    poll_abs(1'b0, 32'd0);               // idle level, nothing happens
    poll_abs(1'b1, 32'd10);              // raw edge, not yet steady
    poll_abs(1'b1, 32'd59);              // one ms short of the debounce time
    poll_abs(1'b1, 32'd60);              // press accepted, changed set
    poll_abs(1'b0, 32'd62);              // unaccepted edge keeps changed
    poll_abs(1'b0, 32'd70);              // steady poll clears changed
    poll_abs(1'b1, 32'd80);              // back to pressed raw, stable unchanged
    poll_abs(1'b1, 32'd310);             // exactly long_press_ms after the press
    poll_abs(1'b0, 32'd320);
    poll_abs(1'b0, 32'd370);             // release accepted, long press flag kept
    poll_abs(1'b0, 32'd371);
    poll_abs(1'b1, 32'hFFFF_FFF0);       // press edge just before the wrap
    poll_abs(1'b1, 32'h0000_0030);       // accepted across the wrap
    poll_abs(1'b1, 32'hFFFF_FFFF);       // timestamp goes backwards: huge interval

    // writes to unknown indexes must leave both intervals alone
    write_reg(CfgUnusedA, 16'hFFFF);
    write_reg(CfgUnusedB, 16'hFFFF);
    poll_abs(1'b0, 32'h0000_0100);       // still 50 ms debounce, not accepted

    // zero intervals: accept on first sight, flag long press on the first poll after the press is accepted
    write_reg(CfgDebounceMs, 16'd0);
    write_reg(CfgLongPressMs, 16'd0);
    poll_abs(1'b0, 32'h0000_0100);
    poll_abs(1'b1, 32'h5555_5555);
    poll_abs(1'b1, 32'h5555_5555);
    poll_abs(1'b0, 32'hAAAA_AAAA);

    // interval settings per phase, extremes included; the last one is random
    db_tab = '{16'd0, 16'd65535, 16'd5, 16'd1, 16'd0, 16'd65535, 16'd3, 16'd0};
    lp_tab = '{16'd0, 16'd65535, 16'd20, 16'd0, 16'd65535, 16'd0, 16'd12, 16'd0};
    db_tab[NumPhases-1] = IntvW'($urandom_range(0, 40));
    lp_tab[NumPhases-1] = IntvW'($urandom_range(0, 200));

    for (phase = 0; phase < NumPhases; phase++) begin
      write_reg(CfgDebounceMs, db_tab[phase]);
      write_reg(CfgLongPressMs, lp_tab[phase]);
      no_stall  = (phase == 2);
      phase_end = issued + PhaseItems;
      while (issued < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 68) begin
          press_episode();
        end else if (pick < 78) begin
          // random levels at random pace
          repeat ($urandom_range(1, 6))
            poll_at(1'(($urandom_range(0, 1))), $urandom_range(0, db_cur + lp_cur + 2));
        end else if (pick < 85) begin
          // chatter toward pressed, then a release poll; steps are at most a quarter of the debounce time plus one ms
          bounce_to(1'b1);
          poll_at(1'b0, $urandom_range(0, db_cur / 4 + 1));
        end else if (pick < 90) begin
          // arbitrary timestamps, out of order included
          repeat ($urandom_range(1, 4)) poll_abs(1'($urandom_range(0, 1)), $urandom());
        end else if (pick < 93) begin
          // sender holds off until everything has come back
          drain_polls();
        end else begin
          // land just before the wrap and run an episode across it
          now_ms_r = 32'hFFFF_FFFF - TimeW'($urandom_range(0, 2 * db_cur + 2));
          press_episode();
        end
      end
    end
    no_stall = 1'b0;

    drain_polls();
    repeat (4) @(negedge clk_i);
    if (fail_count == 0 && awaiting == 0) begin
      $display("button_debounce_long_press_top_tb: PASS");
    end else begin
      $display("button_debounce_long_press_top_tb: FAIL");
    end
    $finish;
  end

  // hard stop in case a handshake never completes
  initial begin
    #(RunLimit);
    $display("button_debounce_long_press_top_tb: FAIL");
    $finish;
  end

endmodule

[button_debounce_long_press_top.f]
design/bdlp_pkg.sv
design/bdlp_if.sv
design/bdlp_core.sv
design/button_debounce_long_press_top.sv
tb/bdlp_poll_checker.sv
tb/button_debounce_long_press_top_tb.sv
